FILE: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the short twister random number unit.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam logic [1:0] MODE_RESEED = 2'd0;
  localparam logic [1:0] MODE_XOR    = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;

  localparam logic [31:0] TWIST_XOR = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT = 32'd1712438297;
  localparam logic [31:0] TEMPER_B  = 32'h9C4F_88E3;
  localparam logic [31:0] TEMPER_C  = 32'hE7F7_0000;
  localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS  = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_W0,
    ST_RS_MUL,
    ST_RS_WR,
    ST_XO_RD,
    ST_XO_WR,
    ST_TW_R0,
    ST_TW_RN,
    ST_TW_RT,
    ST_TW_WR,
    ST_DR_RD,
    ST_DR_CAP
  } stp_state_t;

endpackage

FILE: hdl/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/short_twister_prng_unit.sv
// ----------------------------------------------------------------------------
// short_twister_prng_unit
// Shortened twister-style generator with state words held in a RAM.
// ----------------------------------------------------------------------------
// Input beat: in_mode selects reseed (in_value is the seed), xor (in_value
// is mixed into word in_word_index) or draw. Only a draw gives an output
// beat, out_random_word. Unused mode 3 and an xor index beyond the state
// are taken and dropped.
// One item is worked at a time; in_ready is high only while idle.
// Steps per item, all set by the single RAM read port and the sequencer:
//   reseed: write the seed to word 0, then per word one multiply, then one add and write.
//   xor:    read, modify, write.
//   draw:   read, then load the output register; the state twists first
//           when the read position has run out.
// The output register holds one finished word; while it is full and
// out_ready is low, a following draw waits before loading it, and in_ready
// stays low. Reset clears control state and sets the read position to the
// end, so the first draw after a reseed twists. State words are undefined
// until the first reseed.
// ----------------------------------------------------------------------------
module short_twister_prng_unit #(
  parameter int STATE_WORDS = 64,
  parameter int TAP_OFFSET  = 39
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_word_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word
);

  localparam int AW      = $clog2(STATE_WORDS);
  localparam int PW      = $clog2(STATE_WORDS + 1);
  localparam int TAP_MOD = TAP_OFFSET % STATE_WORDS;
  localparam logic [AW-1:0] LAST_IDX   = AW'(STATE_WORDS - 1);
  localparam logic [PW-1:0] POS_END    = PW'(STATE_WORDS);
  localparam logic [AW:0]   WORDS_EXT  = (AW+1)'(STATE_WORDS);
  localparam logic [AW:0]   TAP_EXT    = (AW+1)'(TAP_MOD);

  stp_pkg::stp_state_t state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   next_r, next_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_word_r, out_word_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [AW:0]   tap_sum;
  logic [AW-1:0] tap_wrap;
  logic [AW-1:0] tap_addr;
  logic [31:0]   mult_lo;
  logic [31:0]   mixed;
  logic [31:0]   seed_word;
  logic [31:0]   twist_y;
  logic          odd_bit;
  logic [31:0]   twist_word;
  logic [31:0]   tempered;
  logic          idx_ok;
  logic          slot_free;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & stp_pkg::TEMPER_B);
    y = y ^ ((y << 15) & stp_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  stp_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_words (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign tap_sum  = {1'b0, k_r} + TAP_EXT;
  assign tap_wrap = AW'(tap_sum - WORDS_EXT);
  assign tap_addr = (tap_sum >= WORDS_EXT) ? tap_wrap : tap_sum[AW-1:0];

  assign mixed      = prev_r ^ (prev_r >> 30);
  assign mult_lo    = mixed * stp_pkg::SEED_MULT;
  assign seed_word  = prod_r + 32'(k_r);

  assign twist_y    = (cur_r & stp_pkg::HIGH_BIT) | ((next_r & stp_pkg::LOW_BITS) >> 1);
  assign odd_bit    = (k_r == LAST_IDX) ? cur_r[0] : next_r[0];
  assign twist_word = ram_rdata ^ twist_y ^ (odd_bit ? stp_pkg::TWIST_XOR : 32'd0);

  assign tempered   = temper(ram_rdata);
  assign idx_ok     = ({26'd0, in_word_index} < 32'(STATE_WORDS));
  assign slot_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stp_pkg::ST_IDLE;
      pos_r       <= POS_END;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = prev_r;
    ram_re        = 1'b0;
    ram_raddr     = k_r;

    case (state_r)
      stp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          prev_nxt = in_value;
          idx_nxt  = in_word_index;
          case (in_mode)
            stp_pkg::MODE_RESEED: state_nxt = stp_pkg::ST_RS_W0;
            stp_pkg::MODE_XOR: begin
              if (idx_ok) begin
                state_nxt = stp_pkg::ST_XO_RD;
              end
            end
            stp_pkg::MODE_DRAW: begin
              if (pos_r == POS_END) begin
                state_nxt = stp_pkg::ST_TW_R0;
              end else begin
                state_nxt = stp_pkg::ST_DR_RD;
              end
            end
            default: state_nxt = stp_pkg::ST_IDLE;
          endcase
        end
      end

      stp_pkg::ST_RS_W0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = prev_r;
        k_nxt     = AW'(1);
        state_nxt = stp_pkg::ST_RS_MUL;
      end

      stp_pkg::ST_RS_MUL: begin
        prod_nxt  = mult_lo;
        state_nxt = stp_pkg::ST_RS_WR;
      end

      stp_pkg::ST_RS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = seed_word;
        prev_nxt  = seed_word;
        if (k_r == LAST_IDX) begin
          pos_nxt   = POS_END;
          state_nxt = stp_pkg::ST_IDLE;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = stp_pkg::ST_RS_MUL;
        end
      end

      stp_pkg::ST_XO_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(idx_r);
        state_nxt = stp_pkg::ST_XO_WR;
      end

      stp_pkg::ST_XO_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = ram_rdata ^ prev_r;
        state_nxt = stp_pkg::ST_IDLE;
      end

      stp_pkg::ST_TW_R0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        k_nxt     = '0;
        state_nxt = stp_pkg::ST_TW_RN;
      end

      stp_pkg::ST_TW_RN: begin
        if (k_r == '0) begin
          cur_nxt = ram_rdata;
        end
        ram_re    = 1'b1;
        ram_raddr = (k_r == LAST_IDX) ? '0 : k_r + AW'(1);
        state_nxt = stp_pkg::ST_TW_RT;
      end

      stp_pkg::ST_TW_RT: begin
        next_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = tap_addr;
        state_nxt = stp_pkg::ST_TW_WR;
      end

      stp_pkg::ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = twist_word;
        cur_nxt   = next_r;
        if (k_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = stp_pkg::ST_DR_RD;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = stp_pkg::ST_TW_RN;
        end
      end

      stp_pkg::ST_DR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r[AW-1:0];
        state_nxt = stp_pkg::ST_DR_CAP;
      end

      stp_pkg::ST_DR_CAP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = tempered;
          pos_nxt       = pos_r + PW'(1);
          state_nxt     = stp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = stp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

FILE: hdl/stp_checker.sv
// ----------------------------------------------------------------------------
// stp_checker
// Port-level checks for the short twister random number unit.
// ----------------------------------------------------------------------------
module stp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_random_word
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("output beat dropped or changed while stalled");

  // reset leaves no output beat pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reseed and draw leave the unit busy in the cycle after they are taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_mode == stp_pkg::MODE_RESEED || in_mode == stp_pkg::MODE_DRAW)
    |=> !in_ready)
    else $error("ready right after a reseed or draw beat");

  // non-draw items never create an output beat
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != stp_pkg::MODE_DRAW && !out_valid
    |=> !out_valid)
    else $error("output beat from a non-draw item");

endmodule

bind short_twister_prng_unit stp_checker u_stp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_random_word(out_random_word)
);
